[hdl/abst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abst_pkg
// shared types and codes of the array binary search tree block
// ----------------------------------------------------------------------------
package abst_pkg;

	localparam int VALUE_BITS = 16;

	// command codes of the request word
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_PRE    = 2'd1;
	localparam logic [1:0] CMD_IN     = 2'd2;
	localparam logic [1:0] CMD_POST   = 2'd3;

	// status codes of the result word
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_DROPPED  = 3'd1;
	localparam logic [2:0] ST_ZERO     = 3'd2;
	localparam logic [2:0] ST_ELEMENT  = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	// node pointer moves
	localparam logic [1:0] MV_HOLD   = 2'd0;
	localparam logic [1:0] MV_LEFT   = 2'd1;
	localparam logic [1:0] MV_RIGHT  = 2'd2;
	localparam logic [1:0] MV_PARENT = 2'd3;

	typedef struct packed {
		logic [1:0]                   cmd;
		logic signed [VALUE_BITS-1:0] value;
	} abst_req_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value_res;
		logic [2:0]                   status;
		logic                         last;
	} abst_res_t;

	// controller to datapath
	typedef struct packed {
		logic       load;     // capture request, pointer to root
		logic [1:0] move;     // pointer move
		logic       emit;     // walk element at current node
		logic       wr;       // store value at current node
		logic       post;     // send insert result
		logic [2:0] post_st;  // its status
		logic       flush;    // send final walk result
	} abst_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic node_in_range;
		logic node_busy;
		logic left_busy;
		logic right_busy;
		logic at_root;
		logic node_odd;
		logic val_zero;
		logic less;
	} abst_stat_t;

endpackage
`default_nettype wire

[hdl/array_binary_search_tree.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// array_binary_search_tree
// binary search tree held in an implicit array, with insert and three walks
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low, and one word is worked
// on at a time. An insert passes each occupied level with a read of the
// single write port value store and then the compare, then stores or rejects
// the value, and gives one result word. A walk visits every stored node
// three times, one step a cycle, and gives one element word per stored value,
// or one empty word for an empty tree. Result words come from a register,
// each shown for exactly one cycle with strobe high; the receiver cannot
// stall and must take every word. Slot occupancy lives in flip-flops cleared
// by reset, so the tree is empty at once after reset with no clearing pass.
// ----------------------------------------------------------------------------
module array_binary_search_tree import abst_pkg::*; #(
	parameter int TREE_SLOTS = 63
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire abst_req_t req,
	output abst_res_t      res,
	output logic           strobe
);

	// command and status between sequencer and datapath
	abst_cmd_t  cmd;
	abst_stat_t stat;

	// sequencer: insert descent and stackless walk over parent links
	abst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req_cmd(req.cmd),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// datapath: node pointer, occupancy bits, value store, result word
	abst_dp #(
		.TREE_SLOTS(TREE_SLOTS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.stat  (stat),
		.res   (res),
		.strobe(strobe)
	);

endmodule
`default_nettype wire

[hdl/abst_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abst_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module abst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 63
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[hdl/abst_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abst_ctrl
// sequencer for insert descent and stackless tree walks
// ----------------------------------------------------------------------------
module abst_ctrl import abst_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] req_cmd,
	input  wire abst_stat_t stat,
	output logic            busy,
	output abst_cmd_t       cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_INS_READ = 3'd1;
	localparam logic [2:0] S_INS_CMP  = 3'd2;
	localparam logic [2:0] S_WALK     = 3'd3;
	localparam logic [2:0] S_DRAIN    = 3'd4;
	localparam logic [2:0] S_FLUSH    = 3'd5;

	// where the walk stands at the current node
	localparam logic [1:0] PH_DOWN       = 2'd0;
	localparam logic [1:0] PH_LEFT_DONE  = 2'd1;
	localparam logic [1:0] PH_RIGHT_DONE = 2'd2;

	logic [2:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic [1:0] order_q, order_d;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_DOWN;
			order_q <= CMD_INSERT;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			order_q <= order_d;
		end
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		order_d = order_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					order_d  = req_cmd;
					phase_d  = PH_DOWN;
					state_d  = (req_cmd == CMD_INSERT) ? S_INS_READ : S_WALK;
				end
			end
			S_INS_READ: begin
				if (stat.val_zero) begin
					cmd.post    = 1'b1;
					cmd.post_st = ST_ZERO;
					state_d     = S_IDLE;
				end else if (!stat.node_in_range) begin
					cmd.post    = 1'b1;
					cmd.post_st = ST_DROPPED;
					state_d     = S_IDLE;
				end else if (!stat.node_busy) begin
					cmd.wr      = 1'b1;
					cmd.post    = 1'b1;
					cmd.post_st = ST_INSERTED;
					state_d     = S_IDLE;
				end else begin
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				cmd.move = stat.less ? MV_LEFT : MV_RIGHT;
				state_d  = S_INS_READ;
			end
			S_WALK: begin
				unique case (phase_q)
					PH_DOWN: begin
						if (!stat.node_busy) begin
							state_d = S_DRAIN;
						end else begin
							cmd.emit = (order_q == CMD_PRE);
							if (stat.left_busy) begin
								cmd.move = MV_LEFT;
							end else begin
								phase_d = PH_LEFT_DONE;
							end
						end
					end
					PH_LEFT_DONE: begin
						cmd.emit = (order_q == CMD_IN);
						if (stat.right_busy) begin
							cmd.move = MV_RIGHT;
							phase_d  = PH_DOWN;
						end else begin
							phase_d = PH_RIGHT_DONE;
						end
					end
					PH_RIGHT_DONE: begin
						cmd.emit = (order_q == CMD_POST);
						if (stat.at_root) begin
							state_d = S_DRAIN;
						end else begin
							cmd.move = MV_PARENT;
							phase_d  = stat.node_odd ? PH_LEFT_DONE : PH_RIGHT_DONE;
						end
					end
					default: begin
						state_d = S_DRAIN;
					end
				endcase
			end
			S_DRAIN: begin
				state_d = S_FLUSH;
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[hdl/abst_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abst_dp
// node pointer, occupancy bits, value store and result register
// ----------------------------------------------------------------------------
module abst_dp import abst_pkg::*; #(
	parameter int TREE_SLOTS = 63
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire abst_req_t req,
	input  wire abst_cmd_t cmd,
	output abst_stat_t     stat,
	output abst_res_t      res,
	output logic           strobe
);

	localparam int IDX_W  = $clog2(TREE_SLOTS);
	localparam int NODE_W = $clog2(2 * TREE_SLOTS + 1);

	logic [NODE_W-1:0]     node_q;
	logic [NODE_W-1:0]     left, right, parent;
	logic [IDX_W-1:0]      node_idx;
	logic signed [VALUE_BITS-1:0] value_q;
	logic [TREE_SLOTS-1:0] occ_q;
	logic [VALUE_BITS-1:0] rd_data;
	logic [VALUE_BITS-1:0] pend_q;
	logic                  pend_vld_q;
	logic                  emit_d_q;
	abst_res_t             res_q, res_d;
	logic                  strobe_q, strobe_d;

	assign node_idx = node_q[IDX_W-1:0];
	assign left     = {node_q[NODE_W-2:0], 1'b0} + NODE_W'(1);
	assign right    = {node_q[NODE_W-2:0], 1'b0} + NODE_W'(2);
	assign parent   = (node_q - NODE_W'(1)) >> 1;

	assign stat.node_in_range = (node_q < NODE_W'(TREE_SLOTS));
	assign stat.node_busy     = stat.node_in_range && occ_q[node_idx];
	assign stat.left_busy     = (left < NODE_W'(TREE_SLOTS)) && occ_q[left[IDX_W-1:0]];
	assign stat.right_busy    = (right < NODE_W'(TREE_SLOTS)) && occ_q[right[IDX_W-1:0]];
	assign stat.at_root       = (node_q == '0);
	assign stat.node_odd      = node_q[0];
	assign stat.val_zero      = (value_q == '0);
	assign stat.less          = (value_q < $signed(rd_data));

	abst_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(TREE_SLOTS)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr),
		.waddr(node_idx),
		.wdata(value_q),
		.raddr(node_idx),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q     <= '0;
			occ_q      <= '0;
			pend_vld_q <= 1'b0;
			emit_d_q   <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				node_q <= '0;
			end else begin
				unique case (cmd.move)
					MV_LEFT:   node_q <= left;
					MV_RIGHT:  node_q <= right;
					MV_PARENT: node_q <= parent;
					default:   node_q <= node_q;
				endcase
			end
			if (cmd.wr) begin
				occ_q[node_idx] <= 1'b1;
			end
			if (cmd.load) begin
				pend_vld_q <= 1'b0;
			end else if (emit_d_q) begin
				pend_vld_q <= 1'b1;
			end
			emit_d_q <= cmd.emit;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= req.value;
		end
		if (emit_d_q) begin
			pend_q <= rd_data;
		end
		res_q <= res_d;
	end

	// one word is held back so the final element can carry last
	always_comb begin
		strobe_d = 1'b0;
		res_d    = '0;
		priority if (cmd.post) begin
			strobe_d     = 1'b1;
			res_d.status = cmd.post_st;
			res_d.last   = 1'b1;
		end else if (cmd.flush) begin
			strobe_d   = 1'b1;
			res_d.last = 1'b1;
			if (pend_vld_q) begin
				res_d.value_res = pend_q;
				res_d.status    = ST_ELEMENT;
			end else begin
				res_d.status = ST_EMPTY;
			end
		end else if (emit_d_q && pend_vld_q) begin
			strobe_d        = 1'b1;
			res_d.value_res = pend_q;
			res_d.status    = ST_ELEMENT;
		end else begin
			strobe_d = 1'b0;
		end
	end

	assign res    = res_q;
	assign strobe = strobe_q;

endmodule
`default_nettype wire

[hdl/abst_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abst_checker
// port level checks of the array binary search tree block
// ----------------------------------------------------------------------------
module abst_checker import abst_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire logic      busy,
	input wire abst_res_t res,
	input wire logic      strobe
);

	// every taken word makes the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after a taken word");

	// insert and empty results are single words
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && res.status != ST_ELEMENT |-> res.last)
		else $error("non-element result without last");

	// only walk elements carry a value
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && res.status != ST_ELEMENT |-> res.value_res == '0)
		else $error("non-element result with a value");

	// no result while the block is idle and was already idle before
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !$past(busy) |-> !strobe)
		else $error("result while idle");

endmodule

bind array_binary_search_tree abst_checker u_abst_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.res   (res),
	.strobe(strobe)
);
`default_nettype wire
